@@ design/sxq_pkg.sv @@
// Shared types and constants for the serial XON/XOFF queue engine.
// No dependencies; imported by sxq_queue_mem and serial_xon_xoff_queue_engine.
package sxq_pkg;

    // default queue depth in bytes
    localparam int QUEUE_DEPTH_DEF = 64;

    // 7-bit strip mask
    localparam logic [7:0] STRIP_MASK = 8'h7f;

    // mode flag bit positions
    localparam int MF_STRIP  = 0;
    localparam int MF_TXFC   = 1;
    localparam int MF_ANY    = 2;
    localparam int MF_RXFC   = 3;
    localparam int MF_CRNL   = 4;
    localparam int MF_NLCRNL = 5;

    // register reset values
    localparam logic [5:0] MODE_RST = 6'd0;
    localparam logic [7:0] XON_RST  = 8'd17;
    localparam logic [7:0] XOFF_RST = 8'd19;
    localparam logic [7:0] EOL_RST  = 8'd10;
    localparam logic [7:0] CR_RST   = 8'd13;
    localparam logic [6:0] TRIG_RST = 7'd16;

    // event codes of an input beat
    typedef enum logic [1:0] {
        OP_LINE_RX = 2'd0,
        OP_HOST_RD = 2'd1,
        OP_HOST_WR = 2'd2,
        OP_TX_RDY  = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RX_DROP  = 3'd1,
        ST_TX_FULL  = 3'd2,
        ST_RX_EMPTY = 3'd3,
        ST_FLOW     = 3'd4
    } status_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_MODE = 3'd0,
        CFG_XON  = 3'd1,
        CFG_XOFF = 3'd2,
        CFG_EOL  = 3'd3,
        CFG_CR   = 3'd4,
        CFG_TRIG = 3'd5
    } cfg_idx_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WRITE2
    } seq_state_t;

endpackage

@@ design/sxq_queue_mem.sv @@
// Byte queue storage: one write port, one read port with registered read data.
// Depends on sxq_pkg.
module sxq_queue_mem
    import sxq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/serial_xon_xoff_queue_engine.sv @@
// Serial terminal front end with receive/transmit byte queues and XON/XOFF flow control.
// Depends on sxq_pkg and sxq_queue_mem.
//
// One input beat is one event: a byte from the line, a host read, a host write or a
// line transmit-ready tick; every event returns exactly one result beat. Both queues
// sit in single-port-write memories with registered read data, so a host read and a
// transmit tick that sends a queued byte pass through the S_READ state before the
// result, and a host write that expands end of line to CR plus end of line makes its
// second queue write in the S_WRITE2 state; all other events go straight to the
// result register. The result is held in an output register and the next beat is
// taken once it has been accepted, so one event is in flight at a time.
// Configuration writes are accepted in every cycle and take effect at once; they are
// meant to be issued while no event is in flight.
module serial_xon_xoff_queue_engine
    import sxq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input events
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] op
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] line_tx_valid, [8:1] line_tx_byte,
                                   // [9] host_valid, [17:10] host_byte, [23:18] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int WW = (CW > 7) ? CW : 7;
    localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_S  = (AW+1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] TX_LIM   = CW'(QUEUE_DEPTH - 2);
    localparam logic [WW:0]   DEPTH_W  = (WW+1)'(QUEUE_DEPTH);

    // configuration registers
    logic [5:0] mode_reg;
    logic [7:0] xon_reg, xoff_reg, eol_reg, cr_reg;
    logic [6:0] trig_reg;

    // queue and flow state
    logic [AW-1:0] rx_ptr_reg, rx_ptr_next, tx_ptr_reg, tx_ptr_next;
    logic [CW-1:0] rx_cnt_reg, rx_cnt_next, tx_cnt_reg, tx_cnt_next;
    logic          tx_paused_reg, tx_paused_next;
    logic          rx_stopped_reg, rx_stopped_next;
    logic [7:0]    save_reg, save_next;
    logic          src_rx_reg, src_rx_next;
    seq_state_t    state_reg, state_next;

    // result register
    logic          m_valid_reg, m_valid_next;
    logic          txv_reg, txv_next, hv_reg, hv_next;
    logic [7:0]    txb_reg, txb_next, hb_reg, hb_next;
    status_t       st_reg, st_next;

    // memory ports
    logic          rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
    logic [7:0]    rx_wr_data, tx_wr_data, rx_rd_data, tx_rd_data;
    logic [AW-1:0] rx_wr_addr, tx_wr_addr;

    logic          s_fire;
    op_t           op;
    logic [7:0]    byte_c;
    logic [AW:0]   rx_sum, tx_sum;
    logic [CW-1:0] rx_space;
    logic          xoff_low, xon_room;

    assign s_fire    = s_tvalid && s_tready;
    assign op        = op_t'(s_tuser);
    assign cfg_ready = 1'b1;

    // write addresses: read pointer plus fill count, wrapped
    assign rx_sum     = (AW+1)'(rx_ptr_reg) + (AW+1)'(rx_cnt_reg);
    assign tx_sum     = (AW+1)'(tx_ptr_reg) + (AW+1)'(tx_cnt_reg);
    assign rx_wr_addr = (rx_sum >= DEPTH_S) ? AW'(rx_sum - DEPTH_S) : AW'(rx_sum);
    assign tx_wr_addr = (tx_sum >= DEPTH_S) ? AW'(tx_sum - DEPTH_S) : AW'(tx_sum);

    // flow thresholds
    assign rx_space = DEPTH_C - rx_cnt_reg;
    assign xoff_low = WW'(rx_space) < WW'(trig_reg);
    assign xon_room = ((WW+1)'(rx_cnt_reg) + (WW+1)'(trig_reg)) < DEPTH_W;

    // line byte after optional strip
    assign byte_c = mode_reg[MF_STRIP] ? (s_tdata & STRIP_MASK) : s_tdata;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    priority if (op == OP_HOST_RD && rx_cnt_reg != '0) begin
                        state_next = S_READ;
                    end else if (op == OP_TX_RDY && !tx_paused_reg && tx_cnt_reg != '0) begin
                        state_next = S_READ;
                    end else if (op == OP_HOST_WR && tx_cnt_reg <= TX_LIM
                                 && mode_reg[MF_NLCRNL] && s_tdata == eol_reg) begin
                        state_next = S_WRITE2;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_READ:   state_next = S_IDLE;
            S_WRITE2: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        rx_ptr_next     = rx_ptr_reg;
        rx_cnt_next     = rx_cnt_reg;
        tx_ptr_next     = tx_ptr_reg;
        tx_cnt_next     = tx_cnt_reg;
        tx_paused_next  = tx_paused_reg;
        rx_stopped_next = rx_stopped_reg;
        save_next       = save_reg;
        src_rx_next     = src_rx_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        txv_next        = txv_reg;
        txb_next        = txb_reg;
        hv_next         = hv_reg;
        hb_next         = hb_reg;
        st_next         = st_reg;
        rx_wr_en        = 1'b0;
        rx_wr_data      = byte_c;
        rx_rd_en        = 1'b0;
        tx_wr_en        = 1'b0;
        tx_wr_data      = s_tdata;
        tx_rd_en        = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    txv_next = 1'b0;
                    txb_next = '0;
                    hv_next  = 1'b0;
                    hb_next  = '0;
                    st_next  = ST_OK;
                    unique case (op)
                        // byte from the line
                        OP_LINE_RX: begin
                            m_valid_next = 1'b1;
                            if (mode_reg[MF_TXFC] && byte_c == xoff_reg) begin
                                tx_paused_next = 1'b1;
                                st_next        = ST_FLOW;
                            end else if (mode_reg[MF_TXFC] && byte_c == xon_reg) begin
                                tx_paused_next = 1'b0;
                                st_next        = ST_FLOW;
                            end else begin
                                if (mode_reg[MF_TXFC] && mode_reg[MF_ANY]) begin
                                    tx_paused_next = 1'b0;
                                end
                                if (rx_cnt_reg != DEPTH_C) begin
                                    rx_wr_en    = 1'b1;
                                    rx_cnt_next = rx_cnt_reg + 1'b1;
                                    if (mode_reg[MF_RXFC] && xoff_low && !rx_stopped_reg) begin
                                        txv_next        = 1'b1;
                                        txb_next        = xoff_reg;
                                        rx_stopped_next = 1'b1;
                                    end
                                end else begin
                                    st_next = ST_RX_DROP;
                                end
                            end
                        end
                        // host read from the receive queue
                        OP_HOST_RD: begin
                            if (rx_cnt_reg == '0) begin
                                m_valid_next = 1'b1;
                                st_next      = ST_RX_EMPTY;
                            end else begin
                                if (mode_reg[MF_RXFC] && rx_stopped_reg && xon_room) begin
                                    txv_next        = 1'b1;
                                    txb_next        = xon_reg;
                                    rx_stopped_next = 1'b0;
                                end
                                rx_rd_en    = 1'b1;
                                src_rx_next = 1'b1;
                                rx_cnt_next = rx_cnt_reg - 1'b1;
                                rx_ptr_next = (rx_ptr_reg == PTR_LAST) ? '0 : rx_ptr_reg + 1'b1;
                            end
                        end
                        // host write into the transmit queue
                        OP_HOST_WR: begin
                            if (tx_cnt_reg <= TX_LIM) begin
                                tx_wr_en    = 1'b1;
                                tx_cnt_next = tx_cnt_reg + 1'b1;
                                if (mode_reg[MF_NLCRNL] && s_tdata == eol_reg) begin
                                    tx_wr_data = cr_reg;
                                    save_next  = s_tdata;
                                end else begin
                                    m_valid_next = 1'b1;
                                end
                            end else begin
                                m_valid_next = 1'b1;
                                st_next      = ST_TX_FULL;
                            end
                        end
                        // line ready for one byte
                        OP_TX_RDY: begin
                            if (!tx_paused_reg && tx_cnt_reg != '0) begin
                                tx_rd_en    = 1'b1;
                                src_rx_next = 1'b0;
                                tx_cnt_next = tx_cnt_reg - 1'b1;
                                tx_ptr_next = (tx_ptr_reg == PTR_LAST) ? '0 : tx_ptr_reg + 1'b1;
                            end else begin
                                m_valid_next = 1'b1;
                            end
                        end
                        default: m_valid_next = 1'b1;
                    endcase
                end
            end
            // queue read data is back
            S_READ: begin
                m_valid_next = 1'b1;
                if (src_rx_reg) begin
                    hv_next = 1'b1;
                    hb_next = (mode_reg[MF_CRNL] && rx_rd_data == cr_reg) ? eol_reg
                                                                            : rx_rd_data;
                end else begin
                    txv_next = 1'b1;
                    txb_next = tx_rd_data;
                end
            end
            // second byte of an expanded end of line
            S_WRITE2: begin
                m_valid_next = 1'b1;
                tx_wr_en     = 1'b1;
                tx_wr_data   = save_reg;
                tx_cnt_next  = tx_cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_tready = (state_reg == S_IDLE) && !m_valid_reg;
        m_tvalid = m_valid_reg;
        m_tdata  = {6'd0, hb_reg, hv_reg, txb_reg, txv_reg};
        m_tuser  = st_reg;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RST;
            xon_reg  <= XON_RST;
            xoff_reg <= XOFF_RST;
            eol_reg  <= EOL_RST;
            cr_reg   <= CR_RST;
            trig_reg <= TRIG_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MODE: mode_reg <= cfg_data[5:0];
                CFG_XON:  xon_reg  <= cfg_data;
                CFG_XOFF: xoff_reg <= cfg_data;
                CFG_EOL:  eol_reg  <= cfg_data;
                CFG_CR:   cr_reg   <= cfg_data;
                CFG_TRIG: trig_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            rx_ptr_reg     <= '0;
            rx_cnt_reg     <= '0;
            tx_ptr_reg     <= '0;
            tx_cnt_reg     <= '0;
            tx_paused_reg  <= 1'b0;
            rx_stopped_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rx_ptr_reg     <= rx_ptr_next;
            rx_cnt_reg     <= rx_cnt_next;
            tx_ptr_reg     <= tx_ptr_next;
            tx_cnt_reg     <= tx_cnt_next;
            tx_paused_reg  <= tx_paused_next;
            rx_stopped_reg <= rx_stopped_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        save_reg   <= save_next;
        src_rx_reg <= src_rx_next;
        txv_reg    <= txv_next;
        txb_reg    <= txb_next;
        hv_reg     <= hv_next;
        hb_reg     <= hb_next;
        st_reg     <= st_next;
    end

    // receive queue storage
    sxq_queue_mem #(
        .DEPTH (QUEUE_DEPTH)
    ) u_rx_mem (
        .aclk    (aclk),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_wr_addr),
        .wr_data (rx_wr_data),
        .rd_en   (rx_rd_en),
        .rd_addr (rx_ptr_reg),
        .rd_data (rx_rd_data)
    );

    // transmit queue storage
    sxq_queue_mem #(
        .DEPTH (QUEUE_DEPTH)
    ) u_tx_mem (
        .aclk    (aclk),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_wr_addr),
        .wr_data (tx_wr_data),
        .rd_en   (tx_rd_en),
        .rd_addr (tx_ptr_reg),
        .rd_data (tx_rd_data)
    );

endmodule
